[design/tatu_pkg.sv]
// ----------------------------------------------------------------------------
// tatu_pkg: shared types and constants for the thermistor temperature unit
// Register indexes, fixed-point widths, status codes and the per-cell payload.
// ----------------------------------------------------------------------------
package tatu_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int LOG_FRAC = 24;
  localparam int MANT_W = 32;                 // Q30 mantissa, value < 2^32
  localparam int LOG_W = 5 + LOG_FRAC;        // unsigned log2 of a 32-bit value
  localparam int L2_W = LOG_W + 3;            // signed sum of four logs
  localparam int DEN_W = 56;
  localparam int NUM_W = 64;
  localparam int QUO_W = 20;                  // centikelvin quotient bits
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam int TEMP_MAX = 100000;
  localparam int KELVIN_CENTI = 27315;

  localparam logic [2:0] REG_BETA = 3'd0;
  localparam logic [2:0] REG_RREF = 3'd1;
  localparam logic [2:0] REG_RNOM = 3'd2;
  localparam logic [2:0] REG_TNOM = 3'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RAIL = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  // One log2 lane: mantissa being squared and the fraction bits found so far
  typedef struct packed {
    logic [MANT_W-1:0] m;
    logic [4:0] n;
    logic [LOG_FRAC-1:0] frac;
  } log_lane_t;

  // Everything one request carries down the row
  typedef struct packed {
    logic vld;
    logic rail;
    log_lane_t [3:0] lane;                    // rref, code, full-code, rnom
    logic [15:0] beta;
    logic signed [17:0] t0c;
    logic signed [L2_W-1:0] l2;
    logic signed [DEN_W-1:0] den;
    logic [NUM_W-1:0] num;                    // becomes remainder during divide
    logic [QUO_W-1:0] quo;
  } item_t;

endpackage

[design/thermistor_adc_to_temperature_unit.sv]
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature_unit: NTC divider code to centi-degrees C
// Beta-equation conversion as a fixed row of pipeline cells.
// ----------------------------------------------------------------------------
// Usage: pulse start with an ADC code whenever busy is low; busy is never
// raised, so a new request may enter every cycle. The result appears on
// temp_centi_c/status with done high for one cycle once the request has
// passed the cell row (1 input + 24 log cells + 3 arithmetic + 20 divide
// cells + 1 output stage). The receiver cannot stall the row.
// Configuration writes (cfg_we/cfg_index/cfg_data) must only happen while
// no request is in flight.
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature_unit #(
  parameter int ADC_BITS = tatu_pkg::ADC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [11:0] adc_code,
  output logic done,
  output logic signed [17:0] temp_centi_c,
  output logic [1:0] status,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int NLOG = tatu_pkg::LOG_FRAC;
  localparam int NDIV = tatu_pkg::QUO_W;
  localparam logic [31:0] FULL = 32'((64'd1 << ADC_BITS) - 1);

  // configuration registers
  logic [15:0] beta_kelvin;
  logic [19:0] reference_ohms;
  logic [19:0] nominal_ohms;
  logic signed [8:0] nominal_celsius;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta_kelvin <= 16'd3950;
      reference_ohms <= 20'd10000;
      nominal_ohms <= 20'd8000;
      nominal_celsius <= 9'sd25;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tatu_pkg::REG_BETA: beta_kelvin <= cfg_data[15:0];
        tatu_pkg::REG_RREF: reference_ohms <= cfg_data;
        tatu_pkg::REG_RNOM: nominal_ohms <= cfg_data;
        tatu_pkg::REG_TNOM: nominal_celsius <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // normalize one operand: leading-one position and Q30 mantissa
  function automatic tatu_pkg::log_lane_t norm(input logic [31:0] x);
    tatu_pkg::log_lane_t r;
    logic [31:0] v;
    v = (x == 32'd0) ? 32'd1 : x;
    r.n = 5'd0;
    for (int i = 0; i < 32; i++) if (v[i]) r.n = 5'(i);
    r.m = 32'((64'(v) << 30) >> r.n);
    r.frac = '0;
    return r;
  endfunction

  // entry stage
  tatu_pkg::item_t s0, s0_next;
  logic [31:0] code;

  always_comb begin
    code = 32'(adc_code) & FULL;
    s0_next = '0;
    s0_next.vld = start & ~busy;
    s0_next.rail = (code == 32'd0) || (code == FULL);
    s0_next.lane[0] = norm(32'(reference_ohms));
    s0_next.lane[1] = norm(code);
    s0_next.lane[2] = norm(FULL - code);
    s0_next.lane[3] = norm(32'(nominal_ohms));
    s0_next.beta = (beta_kelvin == 16'd0) ? 16'd1 : beta_kelvin;
    s0_next.t0c = 18'(nominal_celsius) * 18'sd100 + 18'(tatu_pkg::KELVIN_CENTI);
  end

  always_ff @(posedge clk) begin
    if (rst) s0.vld <= 1'b0;
    else s0.vld <= s0_next.vld;
    s0[$bits(s0)-2:0] <= s0_next[$bits(s0)-2:0];
  end

  // log2 row: one fraction bit per cell
  tatu_pkg::item_t lrow [NLOG+1];
  assign lrow[0] = s0;
  for (genvar g = 0; g < NLOG; g++) begin : g_log
    tatu_log_cell #(.BIT_POS(NLOG-1-g)) u_cell (
      .clk(clk), .rst(rst), .din(lrow[g]), .dout(lrow[g+1])
    );
  end

  // arithmetic stages: log sum, ln scale, denominator/numerator
  tatu_pkg::item_t a1, a2, a3, a1_next, a2_next, a3_next;
  logic [tatu_pkg::L2_W-1:0] mag;
  logic [63:0] lnmag;
  logic signed [tatu_pkg::DEN_W-1:0] lnq;
  logic [tatu_pkg::LOG_W-1:0] lg [4];

  always_comb begin
    a1_next = lrow[NLOG];
    for (int k = 0; k < 4; k++) lg[k] = {lrow[NLOG].lane[k].n, lrow[NLOG].lane[k].frac};
    a1_next.l2 = $signed(tatu_pkg::L2_W'(lg[0])) + $signed(tatu_pkg::L2_W'(lg[1]))
               - $signed(tatu_pkg::L2_W'(lg[2])) - $signed(tatu_pkg::L2_W'(lg[3]));
  end

  always_comb begin
    a2_next = a1;
    mag = a1.l2[tatu_pkg::L2_W-1] ? tatu_pkg::L2_W'(-a1.l2) : tatu_pkg::L2_W'(a1.l2);
    lnmag = (64'(mag) * 64'(tatu_pkg::LN2_Q30) + (64'd1 << 29)) >> 30;
    lnq = a1.l2[tatu_pkg::L2_W-1] ? -$signed(tatu_pkg::DEN_W'(lnmag))
                                  : $signed(tatu_pkg::DEN_W'(lnmag));
    a2_next.den = lnq;
  end

  always_comb begin
    a3_next = a2;
    a3_next.den = a2.den * tatu_pkg::DEN_W'(a2.t0c)
                + $signed(tatu_pkg::DEN_W'((64'd100 * 64'(a2.beta)) << 24));
    // add half the divisor so truncating division rounds half up
    a3_next.num = ((64'd100 * 64'(a2.beta) * 64'(unsigned'(a2.t0c))) << 24)
                + (64'(unsigned'(a3_next.den)) >> 1);
    a3_next.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a1.vld <= 1'b0; a2.vld <= 1'b0; a3.vld <= 1'b0;
    end else begin
      a1.vld <= a1_next.vld; a2.vld <= a2_next.vld; a3.vld <= a3_next.vld;
    end
    a1[$bits(a1)-2:0] <= a1_next[$bits(a1)-2:0];
    a2[$bits(a2)-2:0] <= a2_next[$bits(a2)-2:0];
    a3[$bits(a3)-2:0] <= a3_next[$bits(a3)-2:0];
  end

  // division row: one quotient bit per cell, MSB first
  tatu_pkg::item_t drow [NDIV+1];
  assign drow[0] = a3;
  for (genvar g = 0; g < NDIV; g++) begin : g_div
    tatu_div_cell #(.BIT_POS(NDIV-1-g)) u_cell (
      .clk(clk), .rst(rst), .din(drow[g]), .dout(drow[g+1])
    );
  end

  // output stage: rail, saturation, offset
  tatu_pkg::item_t fin;
  logic signed [17:0] temp_next;
  logic [1:0] status_next;

  assign fin = drow[NDIV];

  always_comb begin
    if (fin.rail) begin
      temp_next = '0; status_next = tatu_pkg::ST_RAIL;
    end else if (fin.den <= 0 ||
                 fin.quo > tatu_pkg::QUO_W'(tatu_pkg::TEMP_MAX + tatu_pkg::KELVIN_CENTI)) begin
      temp_next = 18'(tatu_pkg::TEMP_MAX); status_next = tatu_pkg::ST_SAT;
    end else begin
      temp_next = 18'(fin.quo) - 18'(tatu_pkg::KELVIN_CENTI);
      status_next = tatu_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= fin.vld;
    temp_centi_c <= temp_next;
    status <= status_next;
  end

  // a quotient too big for its width fills with ones and lands in saturation
  a_rail_status: assert property (@(posedge clk) disable iff (rst)
    done && status == tatu_pkg::ST_RAIL |-> temp_centi_c == 18'sd0)
    else $error("rail result carries a temperature");
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    done && status == tatu_pkg::ST_SAT |-> temp_centi_c == 18'sd100000)
    else $error("saturated result not at limit");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##49 done)
    else $error("request lost in row");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status != 2'd3)
    else $error("bad status");

endmodule

[design/tatu_log_cell.sv]
// ----------------------------------------------------------------------------
// tatu_log_cell: one squaring step of four parallel log2 lanes
// Squares each Q30 mantissa, renormalizes and emits one fraction bit.
// ----------------------------------------------------------------------------
module tatu_log_cell #(
  parameter int BIT_POS = 23
) (
  input  logic clk,
  input  logic rst,
  input  tatu_pkg::item_t din,
  output tatu_pkg::item_t dout
);

  tatu_pkg::item_t dout_next;
  logic [63:0] sq [4];

  always_comb begin
    dout_next = din;
    for (int k = 0; k < 4; k++) begin
      sq[k] = (64'(din.lane[k].m) * 64'(din.lane[k].m)) >> 30;
      if (sq[k] >= (64'd2 << 30)) begin
        dout_next.lane[k].m = sq[k][32:1];
        dout_next.lane[k].frac[BIT_POS] = 1'b1;
      end else begin
        dout_next.lane[k].m = sq[k][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dout.vld <= 1'b0;
    else dout.vld <= dout_next.vld;
    dout[$bits(dout)-2:0] <= dout_next[$bits(dout)-2:0];
  end

endmodule

[design/tatu_div_cell.sv]
// ----------------------------------------------------------------------------
// tatu_div_cell: one restoring-division step
// Compares remainder with den shifted by BIT_POS, emits one quotient bit.
// ----------------------------------------------------------------------------
module tatu_div_cell #(
  parameter int BIT_POS = 0
) (
  input  logic clk,
  input  logic rst,
  input  tatu_pkg::item_t din,
  output tatu_pkg::item_t dout
);

  tatu_pkg::item_t dout_next;
  logic [tatu_pkg::NUM_W+tatu_pkg::QUO_W-1:0] dsh;

  always_comb begin
    dout_next = din;
    dsh = (tatu_pkg::NUM_W + tatu_pkg::QUO_W)'(unsigned'(din.den)) << BIT_POS;
    if (!din.rail && din.den > 0 &&
        dsh <= (tatu_pkg::NUM_W + tatu_pkg::QUO_W)'(din.num)) begin
      dout_next.num = din.num - dsh[tatu_pkg::NUM_W-1:0];
      dout_next.quo[BIT_POS] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dout.vld <= 1'b0;
    else dout.vld <= dout_next.vld;
    dout[$bits(dout)-2:0] <= dout_next[$bits(dout)-2:0];
  end

endmodule
